FILE: design/dmd_pkg.sv
// Shared types, constants and helpers for the D-Bus message deframer.
// No dependencies; dmd_frame, the top level and the checker refer to this package by scope.
package dmd_pkg;

  localparam int unsigned HdrLen      = 16;
  localparam int unsigned CountW      = 5;
  localparam int unsigned LenW        = 32;
  localparam int unsigned LeftW       = 34;
  localparam int unsigned CfgIdxW     = 8;
  localparam int unsigned FifoDepthDef = 2;

  localparam logic [7:0] OrderBig    = 8'h42;  // 'B'
  localparam logic [7:0] OrderLittle = 8'h6C;  // 'l'

  localparam logic [LenW-1:0] MaxMessageLenRst = 32'd134217728;
  localparam logic [LenW-1:0] MaxArrayLenRst   = 32'd67108864;

  localparam logic [CfgIdxW-1:0] RegMaxMessageLength = 8'd0;
  localparam logic [CfgIdxW-1:0] RegMaxArrayLength   = 8'd1;

  typedef enum logic [2:0] {
    StInside   = 3'd0,
    StLast     = 3'd1,
    StBadOrder = 3'd2,
    StTooLarge = 3'd3,
    StDropped  = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    status_e    status;
  } result_t;

  localparam int unsigned ResultW = $bits(result_t);

  function automatic logic [LenW-1:0] swap32(input logic [LenW-1:0] v);
    swap32 = {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

FILE: design/dmd_fifo.sv
// Small register queue between the deframer's stages.
// Depends on nothing; width and depth come from the instantiating module.
module dmd_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: design/dmd_frame.sv
// Framing engine: header capture, length checks and body countdown.
// Depends on dmd_pkg; holds the two limit registers.
module dmd_frame (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic [dmd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [dmd_pkg::LenW-1:0]    cfg_data_i,
  input  logic                        in_valid_i,
  input  logic [7:0]                  in_byte_i,
  output logic                        in_ready_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output dmd_pkg::result_t            out_item_o
);

  localparam logic [dmd_pkg::LeftW-1:0]  HdrLeft = dmd_pkg::LeftW'(dmd_pkg::HdrLen);

  logic [dmd_pkg::LenW-1:0]   max_msg_q, max_arr_q;
  logic [dmd_pkg::CountW-1:0] hdr_cnt_q, hdr_cnt_d;
  logic [7:0]                 order_q, order_d;
  logic [dmd_pkg::LenW-1:0]   body_q, body_d, array_q, array_d;
  logic [dmd_pkg::LeftW-1:0]  left_q, left_d, left_dec;
  logic                       closed_q, closed_d;

  logic [dmd_pkg::LenW-1:0]   array_full, len_n, len_m;
  logic [dmd_pkg::LenW:0]     padded;
  logic [dmd_pkg::LeftW-1:0]  after_hdr, total;
  logic [3:0]                 pos;
  logic                       fire;
  dmd_pkg::status_e           status;
  logic                       start;

  assign in_ready_o  = out_ready_i;
  assign out_valid_o = in_valid_i;
  assign fire        = in_valid_i & out_ready_i;
  assign pos         = hdr_cnt_q[3:0];

  // Length words as seen once the last header byte lands.
  assign array_full = {in_byte_i, array_q[23:0]};
  always_comb begin
    if (order_q == dmd_pkg::OrderBig) begin
      len_n = dmd_pkg::swap32(body_q);
      len_m = dmd_pkg::swap32(array_full);
    end else begin
      len_n = body_q;
      len_m = array_full;
    end
  end
  assign padded    = ({1'b0, len_m} + 33'd7) & ~33'd7;
  assign after_hdr = {1'b0, padded} + {2'b00, len_n};
  assign total     = after_hdr + HdrLeft;
  assign left_dec  = (left_q != '0) ? left_q - 1'b1 : left_q;

  always_comb begin
    hdr_cnt_d = hdr_cnt_q;
    order_d   = order_q;
    body_d    = body_q;
    array_d   = array_q;
    left_d    = left_q;
    closed_d  = closed_q;
    status    = dmd_pkg::StInside;
    start     = 1'b0;
    if (closed_q) begin
      status = dmd_pkg::StDropped;
    end else if (!hdr_cnt_q[4]) begin
      hdr_cnt_d = hdr_cnt_q + 1'b1;
      if (pos == 4'd0) begin
        start   = 1'b1;
        order_d = in_byte_i;
        body_d  = '0;
        array_d = '0;
      end else if (pos[3:2] == 2'b01) begin
        body_d[8*pos[1:0] +: 8] = in_byte_i;
      end else if (pos[3:2] == 2'b11) begin
        array_d[8*pos[1:0] +: 8] = in_byte_i;
      end
      if (pos == 4'd15) begin
        if (order_q != dmd_pkg::OrderBig && order_q != dmd_pkg::OrderLittle) begin
          status   = dmd_pkg::StBadOrder;
          closed_d = 1'b1;
        end else if (len_n > max_msg_q || padded > {1'b0, max_arr_q} ||
                     total > {2'b00, max_msg_q}) begin
          status   = dmd_pkg::StTooLarge;
          closed_d = 1'b1;
        end else if (after_hdr == '0) begin
          status    = dmd_pkg::StLast;
          hdr_cnt_d = '0;
          left_d    = '0;
        end else begin
          left_d = after_hdr;
        end
      end
    end else begin
      left_d = left_dec;
      if (left_dec == '0) begin
        status    = dmd_pkg::StLast;
        hdr_cnt_d = '0;
      end
    end
  end

  assign out_item_o = '{data: in_byte_i, start: start, status: status};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_cnt_q <= '0;
      order_q   <= '0;
      body_q    <= '0;
      array_q   <= '0;
      left_q    <= '0;
      closed_q  <= 1'b0;
    end else if (fire) begin
      hdr_cnt_q <= hdr_cnt_d;
      order_q   <= order_d;
      body_q    <= body_d;
      array_q   <= array_d;
      left_q    <= left_d;
      closed_q  <= closed_d;
    end
  end

  // Limit registers; writes to unknown indexes drop silently.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_msg_q <= dmd_pkg::MaxMessageLenRst;
      max_arr_q <= dmd_pkg::MaxArrayLenRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dmd_pkg::RegMaxMessageLength: max_msg_q <= cfg_data_i;
        dmd_pkg::RegMaxArrayLength:   max_arr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

FILE: design/dbus_message_deframer.sv
// Top level of the D-Bus message deframer: input queue, framing engine, result queue.
// Depends on dmd_pkg, dmd_fifo and dmd_frame.
//
// Usage:
//   Input channel: drive stream_byte_i and raise push; a beat is taken on a
//   rising edge with push high and full low. Bytes are consumed in order.
//   Result channel: while empty is low the oldest result sits on byte_out_o,
//   message_start_o and frame_status_o; raise pop to take it.
//   Config channel: cfg_valid_i with cfg_index_i / cfg_data_i; cfg_ready_o is
//   always high. Index 0 is the message length limit, index 1 the field array
//   limit; other indexes are ignored. Write only while the block is idle.
// Timing:
//   One beat per cycle sustained in both directions while nothing stalls. A byte
//   taken into the input queue moves on to the result queue and its ports;
//   each queue adds one register, a stall can hold the byte in either, and the
//   engine between them is combinational. The length sum and limit compares
//   for the 16th header byte finish in the engine in that byte's own cycle.
// Reset:
//   Both queues empty, header counter at zero, block open, limits at defaults.
// Stall:
//   When pop stays low the result queue fills, the engine holds, then the input
//   queue fills and full rises. No beat is lost.
module dbus_message_deframer #(
  parameter int unsigned FifoDepth = dmd_pkg::FifoDepthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // byte stream in
  input  logic                        push,
  input  logic [7:0]                  stream_byte_i,
  output logic                        full,
  // results out
  output logic                        empty,
  input  logic                        pop,
  output logic [7:0]                  byte_out_o,
  output logic                        message_start_o,
  output logic [2:0]                  frame_status_o,
  // configuration
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [dmd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [dmd_pkg::LenW-1:0]    cfg_data_i
);

  logic             in_empty, in_pop;
  logic [7:0]       in_byte;
  logic             res_full, res_push;
  dmd_pkg::result_t res_in, res_out;

  assign cfg_ready_o = 1'b1;

  // Front: hold raw bytes until the engine can take them.
  dmd_fifo #(
    .Width (8),
    .Depth (FifoDepth)
  ) u_in_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (stream_byte_i),
    .full_o  (full),
    .pop_i   (in_pop),
    .data_o  (in_byte),
    .empty_o (in_empty)
  );

  // Engine: classify one byte per cycle whenever the result queue has room.
  dmd_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (~in_empty),
    .in_byte_i   (in_byte),
    .in_ready_o  (in_pop),
    .out_valid_o (res_push),
    .out_ready_i (~res_full),
    .out_item_o  (res_in)
  );

  // Back: results wait here for the receiver.
  dmd_fifo #(
    .Width (dmd_pkg::ResultW),
    .Depth (FifoDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push & ~res_full),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign byte_out_o      = res_out.data;
  assign message_start_o = res_out.start;
  assign frame_status_o  = res_out.status;

endmodule

FILE: design/dmd_checker.sv
// Port-level checks on the deframer's result channel, bound to the top level.
// Depends on dmd_pkg and dbus_message_deframer.
module dmd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [7:0] byte_out_o,
  input logic       message_start_o,
  input logic [2:0] frame_status_o
);

  logic out_beat, close_beat, closed_seen_q;

  assign out_beat   = pop & ~empty;
  assign close_beat = out_beat &&
                      (frame_status_o == dmd_pkg::StBadOrder ||
                       frame_status_o == dmd_pkg::StTooLarge ||
                       frame_status_o == dmd_pkg::StDropped);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      closed_seen_q <= 1'b0;
    end else if (close_beat) begin
      closed_seen_q <= 1'b1;
    end
  end

  // Results wait unchanged while the receiver stalls.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(byte_out_o) && $stable(frame_status_o))
    else $error("result changed while stalled");

  // A message opens only on an ordinary header byte.
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && message_start_o |-> frame_status_o == dmd_pkg::StInside)
    else $error("message start with non-inside status");

  // Once closed, every later byte is dropped.
  a_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    closed_seen_q && !empty |-> frame_status_o == dmd_pkg::StDropped && !message_start_o)
    else $error("byte not dropped after close");

  // Only defined status codes appear.
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> frame_status_o <= dmd_pkg::StDropped)
    else $error("undefined frame status");

endmodule

bind dbus_message_deframer dmd_checker u_dmd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .empty           (empty),
  .pop             (pop),
  .byte_out_o      (byte_out_o),
  .message_start_o (message_start_o),
  .frame_status_o  (frame_status_o)
);

FILE: tb/sv/tb_top.sv
// Self-checking testbench for dbus_message_deframer: queue-style byte and result sides,
// a configuration write channel, and an in-bench frame tracker that predicts every result.
// Depends on dmd_pkg and the deframer RTL only.
module tb_top;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned MaxReports = 10;

  // Ways to close the deframer at the end of the run; it stays closed until reset.
  typedef enum int unsigned {
    CloseBadOrder,
    CloseBodyLong,
    CloseArrayLong,
    CloseTotalLong,
    CloseTinyLimit
  } close_kind_e;

  logic                        clk_i         = 1'b0;
  logic                        rst_ni        = 1'b0;
  logic                        push          = 1'b0;
  logic [7:0]                  stream_byte_i = 8'd0;
  logic                        full;
  logic                        empty;
  logic                        pop           = 1'b0;
  logic [7:0]                  byte_out_o;
  logic                        message_start_o;
  logic [2:0]                  frame_status_o;
  logic                        cfg_valid_i   = 1'b0;
  logic                        cfg_ready_o;
  logic [dmd_pkg::CfgIdxW-1:0] cfg_index_i   = '0;
  logic [dmd_pkg::LenW-1:0]    cfg_data_i    = '0;

  dbus_message_deframer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .stream_byte_i   (stream_byte_i),
    .full            (full),
    .empty           (empty),
    .pop             (pop),
    .byte_out_o      (byte_out_o),
    .message_start_o (message_start_o),
    .frame_status_o  (frame_status_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Frame tracker: our own copy of the limits and the framing state.
  // ---------------------------------------------------------------------------
  logic [dmd_pkg::LenW-1:0]   lim_msg_len   = dmd_pkg::MaxMessageLenRst;
  logic [dmd_pkg::LenW-1:0]   lim_array_len = dmd_pkg::MaxArrayLenRst;
  logic [dmd_pkg::CountW-1:0] hdr_seen      = '0;
  logic [7:0]                 mark_byte     = 8'd0;
  logic [7:0]                 body_b [4]    = '{default: 8'd0};
  logic [7:0]                 arr_b  [4]    = '{default: 8'd0};
  logic [dmd_pkg::LeftW-1:0]  body_left     = '0;
  logic                       link_closed   = 1'b0;

  logic [7:0]       byte_feed_q [$];    // bytes waiting for the driver
  dmd_pkg::result_t frame_expect_q [$]; // predicted results, oldest first
  int unsigned      mismatches  = 0;
  int unsigned      cycle_count = 0;

  // Round a length up to the next multiple of 8, at full width so nothing wraps.
  function automatic logic [63:0] pad8(input logic [dmd_pkg::LenW-1:0] len);
    return ({32'd0, len} + 64'd7) & ~64'd7;
  endfunction

  // Advance the tracker by one byte and return what the block should report for it.
  function automatic dmd_pkg::result_t track_frame(input logic [7:0] b);
    dmd_pkg::result_t r;
    logic [31:0]      n;
    logic [31:0]      m;
    logic [63:0]      padded;
    logic [63:0]      total;
    r.data   = b;
    r.start  = 1'b0;
    r.status = dmd_pkg::StInside;
    if (link_closed) begin
      r.status = dmd_pkg::StDropped;
    end else if (hdr_seen < dmd_pkg::HdrLen) begin
      if (hdr_seen == 0) begin
        r.start   = 1'b1;
        mark_byte = b;
      end else if (hdr_seen >= 4 && hdr_seen <= 7) begin
        body_b[hdr_seen - 4] = b;
      end else if (hdr_seen >= 12) begin
        arr_b[hdr_seen - 12] = b;
      end
      hdr_seen = hdr_seen + 1'b1;
      if (hdr_seen == dmd_pkg::HdrLen) begin
        // Big-endian puts the first arrival in the top byte; little-endian in the bottom.
        if (mark_byte == dmd_pkg::OrderBig) begin
          n = {body_b[0], body_b[1], body_b[2], body_b[3]};
          m = {arr_b[0], arr_b[1], arr_b[2], arr_b[3]};
        end else begin
          n = {body_b[3], body_b[2], body_b[1], body_b[0]};
          m = {arr_b[3], arr_b[2], arr_b[1], arr_b[0]};
        end
        padded = pad8(m);
        total  = 64'(dmd_pkg::HdrLen) + padded + 64'(n);
        if (mark_byte != dmd_pkg::OrderBig && mark_byte != dmd_pkg::OrderLittle) begin
          r.status    = dmd_pkg::StBadOrder;
          link_closed = 1'b1;
        end else if (n > lim_msg_len || padded > 64'(lim_array_len) ||
                     total > 64'(lim_msg_len)) begin
          r.status    = dmd_pkg::StTooLarge;
          link_closed = 1'b1;
        end else if (total == 64'(dmd_pkg::HdrLen)) begin
          // header-only message: the 16th byte is also the last
          r.status  = dmd_pkg::StLast;
          hdr_seen  = '0;
          body_left = '0;
        end else begin
          body_left = dmd_pkg::LeftW'(total - 64'(dmd_pkg::HdrLen));
        end
      end
    end else begin
      if (body_left != 0) body_left = body_left - 1'b1;
      if (body_left == 0) begin
        r.status = dmd_pkg::StLast;
        hdr_seen = '0;
      end
    end
    return r;
  endfunction

  function automatic void note_mismatch(input string what);
    mismatches++;
    if (mismatches <= MaxReports) $display("[%0t] frame mismatch: %s", $time, what);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: present bytes from the feed queue in bursts with random gaps.
  // Predict each byte on the edge that accepts its beat.
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push          <= 1'b0;
      stream_byte_i <= 8'd0;
      burst_left    <= 0;
      gap_left      <= 0;
    end else begin
      if (push && !full) frame_expect_q.push_back(track_frame(stream_byte_i));
      // Hold the byte while the input queue is full; otherwise pick the next move.
      if (!push || !full) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          push     <= 1'b0;
        end else if (byte_feed_q.size() != 0) begin
          stream_byte_i <= byte_feed_q.pop_front();
          push          <= 1'b1;
          if (burst_left <= 1) begin
            // End of burst: reload, and every so often skip the gap entirely.
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: take results with a stall pattern that changes mode every so often,
  // and check each beat against the oldest prediction.
  // ---------------------------------------------------------------------------
  int unsigned stall_left = 0;
  int unsigned stall_pct  = 0;
  int unsigned stall_max  = 1;
  int unsigned pace_left  = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    dmd_pkg::result_t want;
    if (!rst_ni) begin
      pop        <= 1'b0;
      stall_left <= 0;
      pace_left  <= 0;
    end else begin
      if (pop && !empty) begin
        if (frame_expect_q.size() == 0) begin
          note_mismatch($sformatf("unexpected beat byte=%02h start=%0d status=%0d",
                                  byte_out_o, message_start_o, frame_status_o));
        end else begin
          want = frame_expect_q.pop_front();
          if (byte_out_o !== want.data || message_start_o !== want.start ||
              frame_status_o !== want.status)
            note_mismatch($sformatf(
                "expected byte=%02h start=%0d status=%0d, got byte=%02h start=%0d status=%0d",
                want.data, want.start, want.status,
                byte_out_o, message_start_o, frame_status_o));
        end
      end
      // Switch between free flow, light stalls and long stalls.
      if (pace_left == 0) begin
        pace_left <= $urandom_range(64, 200);
        case ($urandom_range(0, 2))
          0:       begin stall_pct <= 0;  stall_max <= 1;  end
          1:       begin stall_pct <= 30; stall_max <= 3;  end
          default: begin stall_pct <= 60; stall_max <= 12; end
        endcase
      end else begin
        pace_left <= pace_left - 1;
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        pop        <= 1'b0;
      end else begin
        pop <= 1'b1;
        if ($urandom_range(0, 99) < stall_pct) stall_left <= $urandom_range(1, stall_max);
      end
    end
  end

  // Watchdog: a lost or stuck beat ends here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] pick_order();
    return ($urandom_range(0, 1) != 0) ? dmd_pkg::OrderBig : dmd_pkg::OrderLittle;
  endfunction

  // Queue a 16-byte fixed header; filler bytes are random, lengths in the marked order.
  function automatic void queue_header(input logic [7:0] mark, input logic [31:0] n,
                                       input logic [31:0] m);
    logic [7:0]  hdr [16];
    int unsigned sh;
    for (int i = 0; i < 16; i++) hdr[i] = 8'($urandom_range(0, 255));
    hdr[0] = mark;
    for (int i = 0; i < 4; i++) begin
      sh          = (mark == dmd_pkg::OrderBig) ? 8 * (3 - i) : 8 * i;
      hdr[4 + i]  = 8'(n >> sh);
      hdr[12 + i] = 8'(m >> sh);
    end
    foreach (hdr[i]) byte_feed_q.push_back(hdr[i]);
  endfunction

  function automatic void queue_message(input logic [7:0] mark, input logic [31:0] n,
                                        input logic [31:0] m);
    queue_header(mark, n, m);
    repeat (int'(pad8(m)) + int'(n)) byte_feed_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  // Well-formed messages with random content until the budget is spent.
  // With fit set, lengths are drawn against the current limits, often right at them.
  function automatic void queue_random_messages(input int unsigned budget, input bit fit);
    int unsigned start_size;
    logic [31:0] n;
    logic [31:0] m;
    int          room;
    start_size = byte_feed_q.size();
    while (byte_feed_q.size() - start_size < budget) begin
      if (fit) begin
        m = $urandom_range(0, lim_array_len);
        if (pad8(m) > 64'(lim_array_len)) m = lim_array_len & ~32'd7;
        room = int'(lim_msg_len) - int'(dmd_pkg::HdrLen) - int'(pad8(m));
        n = ($urandom_range(0, 3) == 0) ? room : $urandom_range(0, room);
      end else begin
        n = $urandom_range(0, 24);
        m = $urandom_range(0, 24);
      end
      queue_message(pick_order(), n, m);
    end
  endfunction

  // Wait until every byte is sent and every result back, then let the pipeline settle.
  task automatic wait_idle();
    do @(posedge clk_i);
    while (byte_feed_q.size() != 0 || push || frame_expect_q.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  // Write one register; mirror it into the tracker on the accepting edge.
  task automatic write_reg(input logic [dmd_pkg::CfgIdxW-1:0] idx,
                           input logic [dmd_pkg::LenW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == dmd_pkg::RegMaxMessageLength) lim_msg_len = val;
    else if (idx == dmd_pkg::RegMaxArrayLength) lim_array_len = val;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence. Every phase ends with the sender paused until the block drains.
  // ---------------------------------------------------------------------------
  initial begin
    close_kind_e kind;
    logic [7:0]  bad_mark;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: header-only little-endian message, then a big-endian one whose
    // body alternates all-zero and all-one bytes, with a padded field array.
    queue_message(dmd_pkg::OrderLittle, 32'd0, 32'd0);
    queue_header(dmd_pkg::OrderBig, 32'd2, 32'd1);
    for (int i = 0; i < 10; i++) byte_feed_q.push_back((i % 2) ? 8'hFF : 8'h00);
    wait_idle();

    // Tightest limits: only header-only messages fit, with total exactly 16.
    write_reg(dmd_pkg::RegMaxMessageLength, 32'd16);
    write_reg(dmd_pkg::RegMaxArrayLength, 32'd0);
    repeat (3) queue_message(pick_order(), 32'd0, 32'd0);
    wait_idle();

    // Widest limits, plus a write to an unused index that must change nothing.
    write_reg(dmd_pkg::RegMaxMessageLength, 32'hFFFF_FFFF);
    write_reg(dmd_pkg::RegMaxArrayLength, 32'hFFFF_FFFF);
    write_reg(dmd_pkg::CfgIdxW'($urandom_range(2, 255)), $urandom);
    queue_random_messages(160, 1'b0);
    wait_idle();

    // Moderate limits; messages land on and under the edges.
    write_reg(dmd_pkg::RegMaxMessageLength, $urandom_range(48, 120));
    write_reg(dmd_pkg::RegMaxArrayLength, $urandom_range(0, 24));
    queue_random_messages(160, 1'b1);
    wait_idle();

    // Close the block one way, then push trailing bytes that must all be dropped.
    kind = close_kind_e'($urandom_range(0, 4));
    case (kind)
      CloseBadOrder: begin
        do bad_mark = 8'($urandom_range(0, 255));
        while (bad_mark == dmd_pkg::OrderBig || bad_mark == dmd_pkg::OrderLittle);
        queue_header(bad_mark, $urandom, $urandom);
      end
      CloseBodyLong: begin
        queue_header(pick_order(),
                     ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF
                                                 : lim_msg_len + $urandom_range(1, 1000),
                     32'd0);
      end
      CloseArrayLong: queue_header(pick_order(), 32'd0, lim_array_len + $urandom_range(1, 8));
      CloseTotalLong: queue_header(pick_order(), lim_msg_len - 32'd15, 32'd0);
      default: begin
        write_reg(dmd_pkg::RegMaxMessageLength, $urandom_range(0, 15));
        queue_header(pick_order(), 32'd0, 32'd0);
      end
    endcase
    repeat ($urandom_range(16, 32)) byte_feed_q.push_back(8'($urandom_range(0, 255)));
    wait_idle();

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
design/dmd_pkg.sv
design/dmd_fifo.sv
design/dmd_frame.sv
design/dbus_message_deframer.sv
design/dmd_checker.sv
tb/sv/tb_top.sv
